// ===== src/hsvp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvp_pkg
// Shared types, sizes and the gamma table of the HSV to RGB pixel unit.
// ----------------------------------------------------------------------------
package hsvp_pkg;

   // Default depth of the queue between the front and the back part.
   localparam int unsigned QUEUE_DEPTH = 4;

   // One word between front and back: unshaped hexcone channels plus the
   // fields that the back part still needs.
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
      logic        apply_gamma;
      logic [15:0] led_index;
   } hsvp_word_type;

   localparam logic [7:0] GAMMA_LUT [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
        8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
        8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
        8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
        8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
        8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
        8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
        8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
        8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
        8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
        8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
        8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
        8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
        8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
        8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
        8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
        8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
        8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
        8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
        8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
        8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
        8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
   };

endpackage
`default_nettype wire

// ===== src/hsvp_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvp_req_if
// Input channel of the pixel unit: one HSV pixel word per handshake.
// ----------------------------------------------------------------------------
interface hsvp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] hue_angle;
   logic [7:0]  saturation;
   logic [7:0]  brightness;
   logic        apply_gamma;
   logic [15:0] led_index;

   modport source (output valid, hue_angle, saturation, brightness, apply_gamma,
                   led_index, input ready);
   modport sink   (input valid, hue_angle, saturation, brightness, apply_gamma,
                   led_index, output ready);
endinterface
`default_nettype wire

// ===== src/hsvp_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvp_rsp_if
// Result channel of the pixel unit: one RGB pixel word per handshake.
// ----------------------------------------------------------------------------
interface hsvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [15:0] led_position;

   modport source (output valid, red, green, blue, led_position, input ready);
   modport sink   (input valid, red, green, blue, led_position, output ready);
endinterface
`default_nettype wire

// ===== src/hsvp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvp_front
// Accepts input words, scales the hue to 0..1530 and sorts it into one of the
// six hexcone slices, giving unshaped red, green and blue.
// ----------------------------------------------------------------------------
module hsvp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   hsvp_req_if.sink                req_if,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output hsvp_pkg::hsvp_word_type push_data
);
   import hsvp_pkg::*;

   localparam int unsigned HUE_W  = 11;
   localparam int unsigned PROD_W = 27;
   localparam logic [PROD_W-1:0] HUE_SCALE = PROD_W'(1530);
   localparam logic [PROD_W-1:0] HUE_ROUND = PROD_W'(32768);
   localparam logic [HUE_W-1:0]  EDGE_1 = HUE_W'(255);
   localparam logic [HUE_W-1:0]  EDGE_2 = HUE_W'(510);
   localparam logic [HUE_W-1:0]  EDGE_3 = HUE_W'(765);
   localparam logic [HUE_W-1:0]  EDGE_4 = HUE_W'(1020);
   localparam logic [HUE_W-1:0]  EDGE_5 = HUE_W'(1275);
   localparam logic [HUE_W-1:0]  EDGE_6 = HUE_W'(1530);
   localparam logic [7:0]        FULL   = 8'hFF;

   logic               advance;
   logic [PROD_W-1:0]  hue_scaled;

   logic               scale_valid_ff, scale_valid_in;
   logic [HUE_W-1:0]   scale_hue_ff, scale_hue_in;
   logic [7:0]         scale_sat_ff, scale_sat_in;
   logic [7:0]         scale_val_ff, scale_val_in;
   logic               scale_gam_ff, scale_gam_in;
   logic [15:0]        scale_idx_ff, scale_idx_in;

   logic               slice_valid_ff, slice_valid_in;
   hsvp_word_type      slice_word_ff, slice_word_in;

   logic [HUE_W-1:0]   diff;
   logic [7:0]         red, green, blue;

   // Both stages move together; a stage that holds nothing never blocks.
   assign advance      = !slice_valid_ff || push_ready;
   assign req_if.ready = advance;

   assign hue_scaled = PROD_W'(req_if.hue_angle) * HUE_SCALE + HUE_ROUND;

   assign scale_valid_in = advance ? req_if.valid : scale_valid_ff;
   assign scale_hue_in   = advance ? hue_scaled[PROD_W-1:16] : scale_hue_ff;
   assign scale_sat_in   = advance ? req_if.saturation : scale_sat_ff;
   assign scale_val_in   = advance ? req_if.brightness : scale_val_ff;
   assign scale_gam_in   = advance ? req_if.apply_gamma : scale_gam_ff;
   assign scale_idx_in   = advance ? req_if.led_index : scale_idx_ff;

   always_comb begin
      red   = FULL;
      green = '0;
      blue  = '0;
      diff  = '0;
      if (scale_hue_ff < EDGE_2) begin
         if (scale_hue_ff < EDGE_1) begin
            red   = FULL;
            green = scale_hue_ff[7:0];
         end else begin
            diff  = EDGE_2 - scale_hue_ff;
            red   = diff[7:0];
            green = FULL;
         end
      end else if (scale_hue_ff < EDGE_4) begin
         red = '0;
         if (scale_hue_ff < EDGE_3) begin
            diff  = scale_hue_ff - EDGE_2;
            green = FULL;
            blue  = diff[7:0];
         end else begin
            diff  = EDGE_4 - scale_hue_ff;
            green = diff[7:0];
            blue  = FULL;
         end
      end else if (scale_hue_ff < EDGE_6) begin
         if (scale_hue_ff < EDGE_5) begin
            diff = scale_hue_ff - EDGE_4;
            red  = diff[7:0];
            blue = FULL;
         end else begin
            diff = EDGE_6 - scale_hue_ff;
            red  = FULL;
            blue = diff[7:0];
         end
      end
      // The top of the scaled range falls through to pure red.
   end

   assign slice_valid_in = advance ? scale_valid_ff : slice_valid_ff;

   always_comb begin
      slice_word_in = slice_word_ff;
      if (advance) begin
         slice_word_in.red         = red;
         slice_word_in.green       = green;
         slice_word_in.blue        = blue;
         slice_word_in.saturation  = scale_sat_ff;
         slice_word_in.brightness  = scale_val_ff;
         slice_word_in.apply_gamma = scale_gam_ff;
         slice_word_in.led_index   = scale_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_valid_ff <= 1'b0;
         slice_valid_ff <= 1'b0;
      end else begin
         scale_valid_ff <= scale_valid_in;
         slice_valid_ff <= slice_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scale_hue_ff  <= scale_hue_in;
      scale_sat_ff  <= scale_sat_in;
      scale_val_ff  <= scale_val_in;
      scale_gam_ff  <= scale_gam_in;
      scale_idx_ff  <= scale_idx_in;
      slice_word_ff <= slice_word_in;
   end

   assign push_valid = slice_valid_ff;
   assign push_data  = slice_word_ff;

endmodule
`default_nettype wire

// ===== src/hsvp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvp_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module hsvp_queue #(
   parameter int unsigned DEPTH = hsvp_pkg::QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   input  wire hsvp_pkg::hsvp_word_type push_data,
   output logic                         pop_valid,
   input  wire logic                    pop_ready,
   output hsvp_pkg::hsvp_word_type      pop_data
);
   import hsvp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   hsvp_word_type     slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL)
      else $error("queue count beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count missed a pop");

endmodule
`default_nettype wire

// ===== src/hsvp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvp_back
// Applies saturation and value to each channel in two multiply stages, then
// the optional gamma table, into the output register.
// ----------------------------------------------------------------------------
module hsvp_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   output logic                         pop_ready,
   input  wire hsvp_pkg::hsvp_word_type pop_data,
   hsvp_rsp_if.source                   rsp_if
);
   import hsvp_pkg::*;

   localparam logic [7:0] FULL = 8'hFF;

   // First step of the shaping: (c * (s + 1)) >> 8 plus 255 - s.
   // The sum never passes 255; it is kept at nine bits for the next multiply.
   function automatic logic [8:0] sat_step(input logic [7:0] c, input logic [7:0] s);
      logic [16:0] prod;
      prod = {9'b0, c} * ({9'b0, s} + 17'd1);
      return prod[16:8] + {1'b0, FULL - s};
   endfunction

   function automatic logic [7:0] val_step(input logic [8:0] t, input logic [7:0] v);
      logic [17:0] prod;
      prod = {9'b0, t} * ({10'b0, v} + 18'd1);
      return prod[15:8];
   endfunction

   logic          advance;

   logic          sat_valid_ff, sat_valid_in;
   logic [8:0]    sat_red_ff, sat_red_in;
   logic [8:0]    sat_green_ff, sat_green_in;
   logic [8:0]    sat_blue_ff, sat_blue_in;
   logic [7:0]    sat_val_ff, sat_val_in;
   logic          sat_gam_ff, sat_gam_in;
   logic [15:0]   sat_idx_ff, sat_idx_in;

   logic          val_valid_ff, val_valid_in;
   logic [7:0]    val_red_ff, val_red_in;
   logic [7:0]    val_green_ff, val_green_in;
   logic [7:0]    val_blue_ff, val_blue_in;
   logic          val_gam_ff, val_gam_in;
   logic [15:0]   val_idx_ff, val_idx_in;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_red_ff, out_red_in;
   logic [7:0]    out_green_ff, out_green_in;
   logic [7:0]    out_blue_ff, out_blue_in;
   logic [15:0]   out_idx_ff, out_idx_in;

   // The whole back pipeline holds while a finished word waits at the output.
   assign advance   = !out_valid_ff || rsp_if.ready;
   assign pop_ready = advance;

   assign sat_valid_in = advance ? pop_valid : sat_valid_ff;
   assign sat_red_in   = advance ? sat_step(pop_data.red, pop_data.saturation) : sat_red_ff;
   assign sat_green_in = advance ? sat_step(pop_data.green, pop_data.saturation)
                                 : sat_green_ff;
   assign sat_blue_in  = advance ? sat_step(pop_data.blue, pop_data.saturation)
                                 : sat_blue_ff;
   assign sat_val_in   = advance ? pop_data.brightness : sat_val_ff;
   assign sat_gam_in   = advance ? pop_data.apply_gamma : sat_gam_ff;
   assign sat_idx_in   = advance ? pop_data.led_index : sat_idx_ff;

   assign val_valid_in = advance ? sat_valid_ff : val_valid_ff;
   assign val_red_in   = advance ? val_step(sat_red_ff, sat_val_ff) : val_red_ff;
   assign val_green_in = advance ? val_step(sat_green_ff, sat_val_ff) : val_green_ff;
   assign val_blue_in  = advance ? val_step(sat_blue_ff, sat_val_ff) : val_blue_ff;
   assign val_gam_in   = advance ? sat_gam_ff : val_gam_ff;
   assign val_idx_in   = advance ? sat_idx_ff : val_idx_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      out_idx_in   = out_idx_ff;
      if (advance) begin
         out_valid_in = val_valid_ff;
         out_idx_in   = val_idx_ff;
         if (val_gam_ff) begin
            out_red_in   = GAMMA_LUT[val_red_ff];
            out_green_in = GAMMA_LUT[val_green_ff];
            out_blue_in  = GAMMA_LUT[val_blue_ff];
         end else begin
            out_red_in   = val_red_ff;
            out_green_in = val_green_ff;
            out_blue_in  = val_blue_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_valid_ff <= 1'b0;
         val_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sat_valid_ff <= sat_valid_in;
         val_valid_ff <= val_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_red_ff   <= sat_red_in;
      sat_green_ff <= sat_green_in;
      sat_blue_ff  <= sat_blue_in;
      sat_val_ff   <= sat_val_in;
      sat_gam_ff   <= sat_gam_in;
      sat_idx_ff   <= sat_idx_in;
      val_red_ff   <= val_red_in;
      val_green_ff <= val_green_in;
      val_blue_ff  <= val_blue_in;
      val_gam_ff   <= val_gam_in;
      val_idx_ff   <= val_idx_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_idx_ff   <= out_idx_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.red          = out_red_ff;
   assign rsp_if.green        = out_green_ff;
   assign rsp_if.blue         = out_blue_ff;
   assign rsp_if.led_position = out_idx_ff;

endmodule
`default_nettype wire

// ===== src/hsv_to_rgb_gamma_pixel_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_gamma_pixel_unit
// HSV to RGB pixel converter on the six-slice hexcone with optional gamma.
// ----------------------------------------------------------------------------
//  channel   port    direction  word
//  request   req_if  in         hue_angle, saturation, brightness,
//                               apply_gamma, led_index
//  response  rsp_if  out        red, green, blue, led_position
//
// One word is taken per clock while the output does not stall; a word passes
// through two front stages, the queue and three back stages to the output.
// Reset clears the stage valid bits and empties the queue; no payload resets.
// A stall at the output holds the back pipeline, and the queue absorbs up to
// QUEUE_DEPTH words before the front and the request side stall too.
// ----------------------------------------------------------------------------
module hsv_to_rgb_gamma_pixel_unit #(
   parameter int unsigned QUEUE_DEPTH = hsvp_pkg::QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hsvp_req_if.sink   req_if,
   hsvp_rsp_if.source rsp_if
);
   import hsvp_pkg::*;

   logic          push_valid, push_ready;
   hsvp_word_type push_data;
   logic          pop_valid, pop_ready;
   hsvp_word_type pop_data;

   hsvp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   hsvp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hsvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire
